>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the Huffman tree walk decoder.
// No dependencies; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/htwd_pkg.sv
// Types, codes and constants of the Huffman tree walk decoder.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package htwd_pkg;

   localparam int NODE_COUNT_DEF = 512;
   localparam int IDX_W          = 9;
   localparam int SYM_W          = 8;
   localparam int BYTE_BITS      = 8;
   localparam int COUNT_W        = 4;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   typedef struct packed {
      logic             leaf;
      logic [SYM_W-1:0] symbol;
      logic [IDX_W-1:0] left;
      logic [IDX_W-1:0] right;
   } htwd_entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_STEP,
      ST_FLUSH
   } htwd_state_type;

   typedef struct packed {
      logic load;
      logic start_byte;
      logic consume;
      logic descend;
      logic emit;
      logic to_root;
      logic flush;
   } htwd_cmd_type;

   typedef struct packed {
      logic leaf;
      logic bits_zero;
   } htwd_status_type;

endpackage

>>> hw/rtl/htwd_ctrl.sv
// Sequencer of the Huffman tree walk decoder: one step of the walk per cycle.
// Depends on htwd_pkg.
`timescale 1ns / 1ps

module htwd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   req_op,
   input  htwd_pkg::htwd_status_type status,
   output htwd_pkg::htwd_cmd_type    cmd,
   output logic                   busy
);

   htwd_pkg::htwd_state_type state_ff;
   htwd_pkg::htwd_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= htwd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         htwd_pkg::ST_IDLE: begin
            if (start && req_op == htwd_pkg::OP_DECODE) begin
               state_in = htwd_pkg::ST_WALK;
            end
         end
         htwd_pkg::ST_WALK: begin
            priority if (status.bits_zero) begin
               state_in = htwd_pkg::ST_FLUSH;
            end else if (!status.leaf) begin
               state_in = htwd_pkg::ST_STEP;
            end else begin
               state_in = htwd_pkg::ST_WALK;
            end
         end
         htwd_pkg::ST_STEP: begin
            priority if (status.leaf) begin
               state_in = status.bits_zero ? htwd_pkg::ST_FLUSH : htwd_pkg::ST_WALK;
            end else if (status.bits_zero) begin
               state_in = htwd_pkg::ST_FLUSH;
            end else begin
               state_in = htwd_pkg::ST_STEP;
            end
         end
         htwd_pkg::ST_FLUSH: begin
            state_in = htwd_pkg::ST_IDLE;
         end
         default: begin
            state_in = htwd_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = (state_ff != htwd_pkg::ST_IDLE);
      unique case (state_ff)
         htwd_pkg::ST_IDLE: begin
            if (start) begin
               cmd.start_byte = (req_op == htwd_pkg::OP_DECODE);
               cmd.load       = (req_op == htwd_pkg::OP_LOAD);
            end
         end
         htwd_pkg::ST_WALK: begin
            if (!status.bits_zero) begin
               cmd.consume = 1'b1;
               cmd.emit    = status.leaf;
               cmd.to_root = status.leaf;
               cmd.descend = !status.leaf;
            end
         end
         htwd_pkg::ST_STEP: begin
            priority if (status.leaf) begin
               cmd.emit    = 1'b1;
               cmd.to_root = 1'b1;
            end else if (!status.bits_zero) begin
               cmd.consume = 1'b1;
               cmd.descend = 1'b1;
            end else begin
               cmd = '0;
            end
         end
         htwd_pkg::ST_FLUSH: begin
            cmd.flush = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

>>> hw/rtl/htwd_datapath.sv
// Datapath of the Huffman tree walk decoder: node table, walk position,
// bit shifter, one-deep symbol hold and result register. Depends on htwd_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module htwd_datapath #(
   parameter int NODE_COUNT = htwd_pkg::NODE_COUNT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  htwd_pkg::htwd_cmd_type          cmd,
   output htwd_pkg::htwd_status_type       status,
   input  logic [htwd_pkg::IDX_W-1:0]      req_node_index,
   input  logic                            req_node_is_leaf,
   input  logic [htwd_pkg::SYM_W-1:0]      req_node_symbol,
   input  logic [htwd_pkg::IDX_W-1:0]      req_left_child,
   input  logic [htwd_pkg::IDX_W-1:0]      req_right_child,
   input  logic [htwd_pkg::BYTE_BITS-1:0]  req_code_byte,
   input  logic [htwd_pkg::COUNT_W-1:0]    req_bit_count,
   input  logic                            csr_write_en,
   input  logic [htwd_pkg::IDX_W-1:0]      csr_write_data,
   output logic                            rsp_strobe,
   output logic [htwd_pkg::SYM_W-1:0]      rsp_symbol,
   output logic                            rsp_last_of_run
);

   localparam int AW = $clog2(NODE_COUNT);
   localparam logic [htwd_pkg::IDX_W:0] NODE_LIMIT = (htwd_pkg::IDX_W + 1)'(NODE_COUNT);
   localparam logic [htwd_pkg::COUNT_W-1:0] FULL_COUNT = htwd_pkg::COUNT_W'(htwd_pkg::BYTE_BITS);

   htwd_pkg::htwd_entry_type mem [NODE_COUNT];

   htwd_pkg::htwd_entry_type       rd_entry_ff;
   logic                           rd_in_range_ff;
   htwd_pkg::htwd_entry_type       entry;
   logic [htwd_pkg::IDX_W-1:0]     root_ff;
   logic [htwd_pkg::IDX_W-1:0]     cur_ff;
   logic [htwd_pkg::IDX_W-1:0]     cur_in;
   logic [htwd_pkg::IDX_W-1:0]     child;
   logic                           cur_in_range;
   logic                           load_in_range;
   logic [htwd_pkg::BYTE_BITS-1:0] byte_ff;
   logic [htwd_pkg::COUNT_W-1:0]   bits_ff;
   logic [htwd_pkg::COUNT_W-1:0]   bits_sat;
   logic                           pend_valid_ff;
   logic [htwd_pkg::SYM_W-1:0]     pend_symbol_ff;
   logic                           rsp_strobe_ff;
   logic [htwd_pkg::SYM_W-1:0]     rsp_symbol_ff;
   logic                           rsp_last_ff;
   htwd_pkg::htwd_entry_type       load_entry;

   assign entry         = rd_in_range_ff ? rd_entry_ff : '0;
   assign child         = byte_ff[htwd_pkg::BYTE_BITS-1] ? entry.right : entry.left;
   assign cur_in_range  = ({1'b0, cur_in} < NODE_LIMIT);
   assign load_in_range = ({1'b0, req_node_index} < NODE_LIMIT);
   assign bits_sat      = (req_bit_count > FULL_COUNT) ? FULL_COUNT : req_bit_count;

   assign load_entry.leaf   = req_node_is_leaf;
   assign load_entry.symbol = req_node_symbol;
   assign load_entry.left   = req_left_child;
   assign load_entry.right  = req_right_child;

   assign status.leaf       = entry.leaf;
   assign status.bits_zero  = (bits_ff == '0);

   always_comb begin
      priority if (csr_write_en) begin
         cur_in = csr_write_data;
      end else if (cmd.to_root) begin
         cur_in = root_ff;
      end else if (cmd.descend) begin
         cur_in = child;
      end else begin
         cur_in = cur_ff;
      end
   end

   // node table: one write, one registered read of the next walk position
   always_ff @(posedge clock) begin
      if (cmd.load && load_in_range) begin
         mem[req_node_index[AW-1:0]] <= load_entry;
      end
      rd_entry_ff    <= mem[cur_in[AW-1:0]];
      rd_in_range_ff <= cur_in_range;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff       <= '0;
         cur_ff        <= '0;
         bits_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            root_ff <= csr_write_data;
         end
         cur_ff <= cur_in;
         if (cmd.start_byte) begin
            bits_ff <= bits_sat;
         end else if (cmd.consume) begin
            bits_ff <= bits_ff - htwd_pkg::COUNT_W'(1);
         end
         rsp_strobe_ff <= (cmd.emit || cmd.flush) && pend_valid_ff;
         if (cmd.emit) begin
            pend_valid_ff <= 1'b1;
         end else if (cmd.flush) begin
            pend_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_byte) begin
         byte_ff <= req_code_byte;
      end else if (cmd.consume) begin
         byte_ff <= {byte_ff[htwd_pkg::BYTE_BITS-2:0], 1'b0};
      end
      if (cmd.emit) begin
         pend_symbol_ff <= entry.symbol;
      end
      if (cmd.emit || cmd.flush) begin
         rsp_symbol_ff <= pend_symbol_ff;
         rsp_last_ff   <= cmd.flush;
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_symbol      = rsp_symbol_ff;
   assign rsp_last_of_run = rsp_last_ff;

   `ASSERT_SAME(a_emit_on_leaf, clock, reset, cmd.emit, status.leaf, "emit from a non-leaf entry")
   `ASSERT_SAME(a_consume_has_bits, clock, reset, cmd.consume, !status.bits_zero, "bit consumed past count")
   `ASSERT_SAME(a_start_hold_empty, clock, reset, cmd.start_byte, !pend_valid_ff, "symbol held across transactions")
   `ASSERT_SAME(a_strobe_from_hold, clock, reset, rsp_strobe_ff, $past(pend_valid_ff), "result without held symbol")

endmodule

>>> hw/rtl/huffman_tree_walk_decoder.sv
// Top level of the Huffman tree walk decoder: sequencer plus datapath.
// Depends on htwd_pkg, htwd_ctrl and htwd_datapath.
//
//   channel   ports                       handshake
//   request   req_*                       start high while busy low
//   response  rsp_symbol, rsp_last_of_run rsp_strobe, one cycle, no stall
//   csr       csr_write_data              csr_write_en, root node index
//
// Load transaction: writes one node table entry; busy stays low.
// Decode transaction: busy through the walk, step and flush states; at most 8 valid bits
// (req_bit_count, larger counts clamp to 8) are walked, one node table read per cycle.
// Synchronous reset clears the walk position and root to 0; node table is not cleared.
// A result is strobed the cycle after the next symbol is found; the last one the cycle
// after the flush cycle, as busy falls. The receiver cannot stall.
`timescale 1ns / 1ps

module huffman_tree_walk_decoder #(
   parameter int NODE_COUNT = htwd_pkg::NODE_COUNT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_op,
   input  logic [htwd_pkg::IDX_W-1:0]      req_node_index,
   input  logic                            req_node_is_leaf,
   input  logic [htwd_pkg::SYM_W-1:0]      req_node_symbol,
   input  logic [htwd_pkg::IDX_W-1:0]      req_left_child,
   input  logic [htwd_pkg::IDX_W-1:0]      req_right_child,
   input  logic [htwd_pkg::BYTE_BITS-1:0]  req_code_byte,
   input  logic [htwd_pkg::COUNT_W-1:0]    req_bit_count,
   input  logic                            csr_write_en,
   input  logic [htwd_pkg::IDX_W-1:0]      csr_write_data,
   output logic                            rsp_strobe,
   output logic [htwd_pkg::SYM_W-1:0]      rsp_symbol,
   output logic                            rsp_last_of_run
);

   htwd_pkg::htwd_cmd_type    cmd;
   htwd_pkg::htwd_status_type status;

   htwd_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_op),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   htwd_datapath #(
      .NODE_COUNT (NODE_COUNT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_node_index   (req_node_index),
      .req_node_is_leaf (req_node_is_leaf),
      .req_node_symbol  (req_node_symbol),
      .req_left_child   (req_left_child),
      .req_right_child  (req_right_child),
      .req_code_byte    (req_code_byte),
      .req_bit_count    (req_bit_count),
      .csr_write_en     (csr_write_en),
      .csr_write_data   (csr_write_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_symbol       (rsp_symbol),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule
